// ===== hdl/hfwbs_pkg.sv =====
// Shared types and constants for the half-frame white balance steering unit.
`timescale 1ns / 1ps
package hfwbs_pkg;

  localparam int HFWBS_MAX_WIDTH  = 256;
  localparam int HFWBS_MAX_HEIGHT = 256;

  localparam int PIX_W   = 8;
  localparam int THR_W   = 8;
  localparam int GEOM_W  = 9;
  localparam int GAIN_W  = 7;
  localparam int CNT_W   = 17;
  localparam int STEER_W = 8;
  localparam int QUO_W   = 7;
  localparam int TOT_W   = CNT_W + 1;
  localparam int PROD_W  = CNT_W + GAIN_W;
  localparam int DVS_W   = TOT_W + QUO_W - 1;
  localparam int STEP_W  = $clog2(QUO_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int OUT_DATA_W = 48;

  localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(128);
  localparam logic [GEOM_W-1:0] WIDTH_RESET  = GEOM_W'(96);
  localparam logic [GEOM_W-1:0] HEIGHT_RESET = GEOM_W'(96);
  localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(50);
  localparam logic [CNT_W-1:0]  COUNT_MAX    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_GAIN      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic mul;
    logic step;
  } hfwbs_cmd_t;

  typedef struct packed {
    logic at_end;
    logic last_pix;
  } hfwbs_sts_t;

endpackage

// ===== hdl/half_frame_white_balance_steering_unit.sv =====
// Top level of the half-frame white balance steering unit.
`timescale 1ns / 1ps
// Counts pixels brighter than threshold_level in the left and right halves of each
// raster frame and, after the last pixel, returns both counts and the steering value
// turn_gain*(right-left)/(left+right) truncated toward zero (0 when nothing is white).
// Pixels are taken one per clock. After a frame's last pixel its result goes through
// a multiply state, then seven steps of the restoring divider, the last of which also
// raises out_tvalid. The divider registers hold one result; while they are busy, a
// pixel at the position that ends the next frame waits (in_tready low), so a frame that
// ends before the divide is done, or a result left untaken, adds stall cycles. Pixels
// elsewhere in the frame are never held. frame_start restarts counting and drops a
// partial frame.
module half_frame_white_balance_steering_unit import hfwbs_pkg::*; #(
  parameter int MAX_WIDTH  = HFWBS_MAX_WIDTH,
  parameter int MAX_HEIGHT = HFWBS_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_value
  input  logic                  in_tuser,   // [0] frame_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [7:0] steering, [24:8] left count,
                                            // [41:25] right count, [47:42] zero
);

  hfwbs_cmd_t          cmd;
  hfwbs_sts_t          sts;
  logic [STEER_W-1:0]  steering;
  logic [CNT_W-1:0]    left_count, right_count;

  hfwbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hfwbs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .pixel_value (in_tdata),
    .frame_start (in_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .steering    (steering),
    .left_count  (left_count),
    .right_count (right_count)
  );

  assign out_tdata = {{(OUT_DATA_W - STEER_W - 2*CNT_W){1'b0}},
                      right_count, left_count, steering};

endmodule

// ===== hdl/hfwbs_ctrl.sv =====
// Controller: input flow control and sequencing of the end-of-frame divide.
`timescale 1ns / 1ps
module hfwbs_ctrl import hfwbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  hfwbs_sts_t sts,
  output hfwbs_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_tready  = !(sts.at_end && (state_r != S_IDLE));
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.accept = in_tvalid && in_tready;
    cmd.load   = cmd.accept && sts.last_pix;
    cmd.mul    = (state_r == S_MUL);
    cmd.step   = (state_r == S_DIV);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_DIV;
        cnt_nxt   = STEP_W'(QUO_W - 1);
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt     = S_OUT;
          out_valid_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/hfwbs_datapath.sv =====
// Datapath: config registers, raster position, white counters and restoring divider.
`timescale 1ns / 1ps
module hfwbs_datapath import hfwbs_pkg::*; #(
  parameter int MAX_WIDTH  = HFWBS_MAX_WIDTH,
  parameter int MAX_HEIGHT = HFWBS_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [PIX_W-1:0]      pixel_value,
  input  logic                  frame_start,
  input  hfwbs_cmd_t            cmd,
  output hfwbs_sts_t            sts,
  output logic [STEER_W-1:0]    steering,
  output logic [CNT_W-1:0]      left_count,
  output logic [CNT_W-1:0]      right_count
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int GWA = $clog2(MAX_WIDTH + 1);
  localparam int GHA = $clog2(MAX_HEIGHT + 1);
  localparam int GW  = (GWA > GEOM_W) ? GWA : GEOM_W;
  localparam int GH  = (GHA > GEOM_W) ? GHA : GEOM_W;

  logic [THR_W-1:0]  thr_r;
  logic [GEOM_W-1:0] fw_r, fh_r;
  logic [GAIN_W-1:0] gain_r;

  logic [CW-1:0]    col_r, col_eff;
  logic [RW-1:0]    row_r, row_eff;
  logic [CNT_W-1:0] left_r, right_r, left_eff, right_eff, left_nxt, right_nxt;

  logic [GW-1:0] fw_x, w_c;
  logic [GH-1:0] fh_x, h_c;
  logic          white, is_left, last_col, last_row;

  logic [CNT_W-1:0]  lres_r, rres_r;
  logic [GAIN_W-1:0] gres_r;
  logic [CNT_W-1:0]  diff;
  logic [TOT_W-1:0]  total;
  logic [PROD_W-1:0] rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [QUO_W-1:0]  quo_r;
  logic              neg_r, nz_r, take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      fw_r   <= WIDTH_RESET;
      fh_r   <= HEIGHT_RESET;
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r  <= cfg_wdata[THR_W-1:0];
        REG_WIDTH:     fw_r   <= cfg_wdata[GEOM_W-1:0];
        REG_HEIGHT:    fh_r   <= cfg_wdata[GEOM_W-1:0];
        REG_GAIN:      gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_x = GW'(fw_r);
    fh_x = GH'(fh_r);
    if (fw_x < GW'(2))              w_c = GW'(2);
    else if (fw_x > GW'(MAX_WIDTH)) w_c = GW'(MAX_WIDTH);
    else                            w_c = fw_x;
    if (fh_x < GH'(1))               h_c = GH'(1);
    else if (fh_x > GH'(MAX_HEIGHT)) h_c = GH'(MAX_HEIGHT);
    else                             h_c = fh_x;

    col_eff   = frame_start ? '0 : col_r;
    row_eff   = frame_start ? '0 : row_r;
    left_eff  = frame_start ? '0 : left_r;
    right_eff = frame_start ? '0 : right_r;

    white    = pixel_value > thr_r;
    is_left  = GW'(col_eff) < (w_c >> 1);
    last_col = GW'(col_eff) >= (w_c - GW'(1));
    last_row = GH'(row_eff) >= (h_c - GH'(1));

    left_nxt  = left_eff;
    right_nxt = right_eff;
    if (white && is_left && (left_eff != COUNT_MAX))    left_nxt  = left_eff + 1'b1;
    if (white && !is_left && (right_eff != COUNT_MAX))  right_nxt = right_eff + 1'b1;

    // position part of the status ignores frame_start so ready never looks at data
    sts.at_end   = (GW'(col_r) >= (w_c - GW'(1))) && (GH'(row_r) >= (h_c - GH'(1)));
    sts.last_pix = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      left_r  <= '0;
      right_r <= '0;
    end else if (cmd.accept) begin
      if (!last_col) begin
        col_r   <= col_eff + 1'b1;
        row_r   <= row_eff;
        left_r  <= left_nxt;
        right_r <= right_nxt;
      end else if (!last_row) begin
        col_r   <= '0;
        row_r   <= row_eff + 1'b1;
        left_r  <= left_nxt;
        right_r <= right_nxt;
      end else begin
        col_r   <= '0;
        row_r   <= '0;
        left_r  <= '0;
        right_r <= '0;
      end
    end
  end

  // divide: |gain*(r-l)| / (l+r), one quotient bit per step, MSB first
  always_comb begin
    diff  = (rres_r >= lres_r) ? (rres_r - lres_r) : (lres_r - rres_r);
    total = TOT_W'(lres_r) + TOT_W'(rres_r);
    take  = nz_r && (DVS_W'(rem_r) >= dvs_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lres_r <= left_nxt;
      rres_r <= right_nxt;
      gres_r <= gain_r;
    end
    if (cmd.mul) begin
      rem_r <= PROD_W'(gres_r) * PROD_W'(diff);
      dvs_r <= {total, {(QUO_W-1){1'b0}}};
      quo_r <= '0;
      neg_r <= rres_r < lres_r;
      nz_r  <= total != '0;
    end else if (cmd.step) begin
      if (take) rem_r <= rem_r - PROD_W'(dvs_r);
      quo_r <= {quo_r[QUO_W-2:0], take};
      dvs_r <= dvs_r >> 1;
    end
  end

  assign steering    = neg_r ? (STEER_W'(0) - STEER_W'(quo_r)) : STEER_W'(quo_r);
  assign left_count  = lres_r;
  assign right_count = rres_r;

endmodule

// ===== hdl/hfwbs_checker.sv =====
// Port-level assertions for the steering unit, bound to the top level.
`timescale 1ns / 1ps
module hfwbs_checker import hfwbs_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result request changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result request right after reset");

  a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] != 8'h80)
    else $error("steering out of range");

  a_no_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[41:8] == '0) |-> out_tdata[7:0] == 8'h00)
    else $error("nonzero steering with no white pixels");

  a_steer_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[7] && (out_tdata[7:0] != 8'h00)
      |-> out_tdata[41:25] > out_tdata[24:8])
    else $error("right turn without right-side majority");

endmodule

bind half_frame_white_balance_steering_unit hfwbs_checker u_hfwbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/hfwbs_result_checker.sv =====
// Result checker for the steering unit: tracks frames, predicts each result and compares it.
`timescale 1ns / 1ps
module hfwbs_result_checker import hfwbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_value
  input  logic                  in_tuser,   // [0] frame_start
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] steering, [24:8] left count,
                                            // [41:25] right count, [47:42] zero
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [STEER_W-1:0] steering;
    logic [CNT_W-1:0]   left_count;
    logic [CNT_W-1:0]   right_count;
  } frame_result_t;

  frame_result_t result_q[$];

  logic [THR_W-1:0]  thr_reg;
  logic [GEOM_W-1:0] width_reg;
  logic [GEOM_W-1:0] height_reg;
  logic [GAIN_W-1:0] gain_reg;

  logic [GEOM_W-1:0] col_pos;
  logic [GEOM_W-1:0] row_pos;
  logic [CNT_W-1:0]  left_cnt;
  logic [CNT_W-1:0]  right_cnt;

  function automatic void clear_frame();
    col_pos   = '0;
    row_pos   = '0;
    left_cnt  = '0;
    right_cnt = '0;
  endfunction

  function automatic void tally_pixel(logic [PIX_W-1:0] pix, logic frame_start);
    logic [GEOM_W-1:0] w;
    logic [GEOM_W-1:0] h;
    longint l;
    longint r;
    longint tot;
    longint st;
    frame_result_t res;
    w = (width_reg < 2) ? GEOM_W'(2) :
        (width_reg > HFWBS_MAX_WIDTH) ? GEOM_W'(HFWBS_MAX_WIDTH) : width_reg;
    h = (height_reg < 1) ? GEOM_W'(1) :
        (height_reg > HFWBS_MAX_HEIGHT) ? GEOM_W'(HFWBS_MAX_HEIGHT) : height_reg;
    if (frame_start) clear_frame();
    if (pix > thr_reg) begin
      if (col_pos < (w >> 1)) begin
        if (left_cnt != COUNT_MAX) left_cnt++;
      end else begin
        if (right_cnt != COUNT_MAX) right_cnt++;
      end
    end
    if (col_pos < w - 1) begin
      col_pos++;
      return;
    end
    col_pos = '0;
    if (row_pos < h - 1) begin
      row_pos++;
      return;
    end
    l   = left_cnt;
    r   = right_cnt;
    tot = l + r;
    st  = (tot != 0) ? (longint'(gain_reg) * (r - l)) / tot : 0;
    res.steering    = STEER_W'(st);
    res.left_count  = left_cnt;
    res.right_count = right_cnt;
    result_q.push_back(res);
    clear_frame();
  endfunction

  function automatic void check_result(logic [OUT_DATA_W-1:0] data);
    frame_result_t     exp_r;
    logic [STEER_W-1:0] got_s;
    logic [CNT_W-1:0]   got_l;
    logic [CNT_W-1:0]   got_r;
    logic [OUT_DATA_W-1:0] pad;
    got_s = data[0 +: STEER_W];
    got_l = data[STEER_W +: CNT_W];
    got_r = data[STEER_W + CNT_W +: CNT_W];
    pad   = data >> (STEER_W + 2 * CNT_W);
    if (result_q.size() == 0) begin
      if (errors < 10) $display("%0t: result with none expected: %h", $time, data);
      errors++;
      return;
    end
    exp_r = result_q.pop_front();
    if (got_s !== exp_r.steering || got_l !== exp_r.left_count ||
        got_r !== exp_r.right_count || pad !== '0) begin
      if (errors < 10)
        $display("%0t: mismatch steering exp %0d got %0d,", $time,
                 $signed(exp_r.steering), $signed(got_s),
                 " left exp %0d got %0d,", exp_r.left_count, got_l,
                 " right exp %0d got %0d, pad %h", exp_r.right_count, got_r, pad);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      thr_reg    = THR_RESET;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      gain_reg   = GAIN_RESET;
      clear_frame();
      result_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_THRESHOLD: thr_reg    = cfg_wdata[THR_W-1:0];
          REG_WIDTH:     width_reg  = cfg_wdata[GEOM_W-1:0];
          REG_HEIGHT:    height_reg = cfg_wdata[GEOM_W-1:0];
          REG_GAIN:      gain_reg   = cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) tally_pixel(in_tdata, in_tuser);
      pending = result_q.size();
    end
  end

endmodule

// ===== verif/half_frame_white_balance_steering_unit_tb.sv =====
// Testbench top for the steering unit: clock, reset, pixel/config stimulus and verdict.
`timescale 1ns / 1ps
module half_frame_white_balance_steering_unit_tb;
  import hfwbs_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata;   // [7:0] pixel_value
  logic                  in_tuser;   // [0] frame_start
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [7:0] steering, [24:8] left count,
                                     // [41:25] right count, [47:42] zero
  int errors;
  int pending;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit rx_hold    = 1'b0;
  logic [THR_W-1:0] cur_thr;
  int frame_len;

  int unsigned set_thr[8]  = '{128, 0, 255, 100, 50, 200, 30, 77};
  int unsigned set_wid[8]  = '{4, 0, 1, 511, 2, 7, 3, 257};
  int unsigned set_hgt[8]  = '{3, 0, 2, 1, 511, 5, 1, 0};
  int unsigned set_gain[8] = '{50, 127, 0, 127, 64, 1, 99, 127};

  half_frame_white_balance_steering_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  hfwbs_result_checker frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin : rx_side
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 400;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = !(rx_idle_on && $urandom_range(99) < 32);
      end
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    logic [PIX_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v = cur_thr;
      3: v = cur_thr + 1'b1;
      4: v = cur_thr - 1'b1;
      default: v = PIX_W'($urandom_range(255));
    endcase
    return v;
  endfunction

  task automatic send_pixel(logic [PIX_W-1:0] pix, logic fs);
    while (tx_idle_on && $urandom_range(99) < 32) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = pix;
    in_tuser  = fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(int unsigned thr, int unsigned wid, int unsigned hgt,
                           int unsigned gain);
    int w;
    int h;
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_WIDTH, CFG_DATA_W'(wid));
    write_reg(REG_HEIGHT, CFG_DATA_W'(hgt));
    write_reg(REG_GAIN, CFG_DATA_W'(gain));
    cur_thr = THR_W'(thr);
    w = (wid < 2) ? 2 : (wid > HFWBS_MAX_WIDTH) ? HFWBS_MAX_WIDTH : wid;
    h = (hgt < 1) ? 1 : (hgt > HFWBS_MAX_HEIGHT) ? HFWBS_MAX_HEIGHT : hgt;
    frame_len = w * h;
  endtask

  // wait until every expected result is out, then let the divider go quiet
  task automatic settle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin : stimulus
    int sent;
    int n;
    int cut_len;
    bit need_start;
    bit fs_bit;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cur_thr   = THR_RESET;
    frame_len = 1;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // 2x2 frames: mixed halves, all right, none white, dropped partial, all left
    configure(128, 2, 2, 127);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd129, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    repeat (4) send_pixel(8'd128, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    settle();

    for (int p = 0; p < 11; p++) begin
      if (p < 8)
        configure(set_thr[p], set_wid[p], set_hgt[p], set_gain[p]);
      else
        configure($urandom_range(255), $urandom_range(12, 2), $urandom_range(6, 1),
                  $urandom_range(127));
      tx_idle_on = !(p == 5 || p == 6);
      rx_idle_on = tx_idle_on;
      if (p == 1) rx_hold = 1'b1;
      sent       = 0;
      need_start = $urandom_range(1);
      while (sent < 84) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(frame_len, 1) : frame_len;
        for (int k = 0; k < n; k++) begin
          if (k == 0) begin
            fs_bit = need_start || ($urandom_range(1) == 1);
            need_start = 1'b0;
          end else begin
            fs_bit = ($urandom_range(199) == 0);
            if (fs_bit) need_start = 1'b1;
          end
          send_pixel(pick_pixel(), fs_bit);
        end
        if (n != frame_len) need_start = 1'b1;
        sent += n;
      end
      // leave a frame partly done so the next geometry lands mid-frame
      if (frame_len <= 64 && $urandom_range(1) == 1) begin
        cut_len = (frame_len - 1 < 10) ? frame_len - 1 : 10;
        n = $urandom_range(cut_len, 1);
        for (int k = 0; k < n; k++) send_pixel(pick_pixel(), 1'b0);
      end
      settle();
    end

    repeat (30) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
